### hw/rtl/hsfc_pkg.sv
// Package: shared types and constants for the half/single float converter.
`default_nettype none
package hsfc_pkg;

	typedef enum logic {
		ACT_PROMOTE = 1'b0,
		ACT_DEMOTE  = 1'b1
	} act_t;

	typedef enum logic [2:0] {
		CLS_ZERO,
		CLS_SUB,
		CLS_NORM,
		CLS_INF,
		CLS_NAN
	} cls_t;

	typedef struct packed {
		act_t        act;
		logic        sign;
		cls_t        cls;
		logic [7:0]  exp8;  // promote: biased single exponent; demote: half exponent
		logic [22:0] frac;  // promote: half fraction in low bits; demote: single fraction
		logic [4:0]  amt;   // promote: leading-one position; demote: subnormal right shift
	} dec_t;

	localparam logic [7:0] EXP_ADJ      = 8'd112;
	localparam logic [7:0] SUB_EXP_BASE = 8'd103;
	localparam logic [7:0] DEM_SUB_BASE = 8'd126;
	localparam logic [7:0] DEM_SUB_MIN  = 8'd102;
	localparam logic [7:0] DEM_NORM_MIN = 8'd113;
	localparam logic [7:0] DEM_INF_MIN  = 8'd143;
	localparam logic [4:0] PRO_SHL_TOP  = 5'd23;

endpackage
`default_nettype wire

### hw/rtl/hsfc_decode.sv
// Decode stage: field split, class detection, leading-one search and shift amount.
`default_nettype none
module hsfc_decode
	import hsfc_pkg::*;
(
	input  wire logic        action,
	input  wire logic [31:0] value_in,
	output dec_t             dec
);

	logic [4:0] h_ex;
	logic [9:0] h_fr;
	logic [7:0] f_ex;
	logic [22:0] f_fr;
	logic [3:0] lead;

	assign h_ex = value_in[14:10];
	assign h_fr = value_in[9:0];
	assign f_ex = value_in[30:23];
	assign f_fr = value_in[22:0];

	always_comb begin
		lead = '0;
		for (int i = 0; i < 10; i++) begin
			if (h_fr[i])
				lead = 4'(i);
		end
	end

	always_comb begin
		dec.act  = act_t'(action);
		dec.sign = 1'b0;
		dec.cls  = CLS_ZERO;
		dec.exp8 = '0;
		dec.frac = '0;
		dec.amt  = '0;
		if (act_t'(action) == ACT_PROMOTE) begin
			dec.sign = value_in[15];
			dec.frac = {13'b0, h_fr};
			if (h_ex == 5'd0) begin
				dec.cls = (h_fr == '0) ? CLS_ZERO : CLS_SUB;
				dec.amt = {1'b0, lead};
			end else if (h_ex == 5'h1F) begin
				dec.cls = (h_fr == '0) ? CLS_INF : CLS_NAN;
			end else begin
				dec.cls  = CLS_NORM;
				dec.exp8 = {3'b0, h_ex} + EXP_ADJ;
			end
		end else begin
			dec.sign = value_in[31];
			dec.frac = f_fr;
			if (f_ex == 8'hFF) begin
				dec.cls = (f_fr == '0) ? CLS_INF : CLS_NAN;
			end else if (f_ex >= DEM_INF_MIN) begin
				dec.cls = CLS_INF;
			end else if (f_ex >= DEM_NORM_MIN) begin
				dec.cls  = CLS_NORM;
				dec.exp8 = f_ex - EXP_ADJ;
			end else if (f_ex >= DEM_SUB_MIN) begin
				dec.cls = CLS_SUB;
				dec.amt = 5'(DEM_SUB_BASE - f_ex);
			end else begin
				dec.cls = CLS_ZERO;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/half_single_float_converter_core.sv
// Top level: three-stage half/single float converter pipeline (decode, shift, round).
// Throughput: one transaction per cycle while out_ready is high; a full stage stalls only when the next cannot move.
// Each stage holds a valid bit; a stage loads when empty or when it moves on.
// Reset: arst_n asynchronously clears all valid bits; payload registers are not reset.
`default_nettype none
module half_single_float_converter_core
	import hsfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [31:0] value_in,
	input  wire logic        last_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      value_out,
	output logic             last_out
);

	dec_t        dec;
	dec_t        dec_s1;
	logic        last_s1, last_s2, last_s3;
	logic        v_s1, v_s2, v_s3;
	logic        rdy1, rdy2, rdy3;
	logic [31:0] base;
	logic        rnd;
	logic [31:0] base_s2, base_s3;
	logic        rnd_s2, rnd_s3;
	act_t        act_s2, act_s3;
	logic [4:0]  shl;
	logic [47:0] wide;

	hsfc_decode u_decode (
		.action  (action),
		.value_in(value_in),
		.dec     (dec)
	);

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= in_valid;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			dec_s1  <= dec;
			last_s1 <= last_in;
		end
		if (rdy2 && v_s1) begin
			base_s2 <= base;
			rnd_s2  <= rnd;
			act_s2  <= dec_s1.act;
			last_s2 <= last_s1;
		end
		if (rdy3 && v_s2) begin
			base_s3 <= {base_s2[31:15], base_s2[14:0] + {14'b0, rnd_s2}};
			rnd_s3  <= rnd_s2;
			act_s3  <= act_s2;
			last_s3 <= last_s2;
		end
	end

	// shift stage
	assign shl  = PRO_SHL_TOP - dec_s1.amt;
	assign wide = {1'b1, dec_s1.frac, 24'b0} >> dec_s1.amt;

	always_comb begin
		base = '0;
		rnd  = 1'b0;
		if (dec_s1.act == ACT_PROMOTE) begin
			unique case (dec_s1.cls)
				CLS_ZERO: base = {dec_s1.sign, 31'b0};
				CLS_SUB:  base = {dec_s1.sign, {3'b0, dec_s1.amt} + SUB_EXP_BASE,
					23'(dec_s1.frac << shl)};
				CLS_NORM: base = {dec_s1.sign, dec_s1.exp8, dec_s1.frac[9:0], 13'b0};
				CLS_INF:  base = {dec_s1.sign, 8'hFF, 23'b0};
				CLS_NAN:  base = {dec_s1.sign, 8'hFF, 1'b1, dec_s1.frac[8:0], 13'b0};
				default:  base = '0;
			endcase
		end else begin
			unique case (dec_s1.cls)
				CLS_ZERO: base = {16'b0, dec_s1.sign, 15'b0};
				CLS_SUB: begin
					base = {16'b0, dec_s1.sign, 5'b0, wide[33:24]};
					rnd  = wide[23] && ((|wide[22:0]) || wide[24]);
				end
				CLS_NORM: begin
					base = {16'b0, dec_s1.sign, dec_s1.exp8[4:0], dec_s1.frac[22:13]};
					rnd  = dec_s1.frac[12] && ((|dec_s1.frac[11:0]) || dec_s1.frac[13]);
				end
				CLS_INF:  base = {16'b0, dec_s1.sign, 5'h1F, 10'b0};
				CLS_NAN:  base = {16'b0, dec_s1.sign, 5'h1F, 1'b1, dec_s1.frac[21:13]};
				default:  base = '0;
			endcase
		end
	end

	assign out_valid = v_s3;
	assign value_out = base_s3;
	assign last_out  = last_s3;

	a_demote_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && act_s3 == ACT_DEMOTE |-> value_out[31:16] == 16'b0)
		else $error("demote result has nonzero upper half");

	a_round_only_demote: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rnd_s3 |-> act_s3 == ACT_DEMOTE)
		else $error("rounding increment on promote result");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy2 |=> v_s1 && $stable(dec_s1) && $stable(last_s1))
		else $error("stage 1 transaction lost during stall");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy3 |=> v_s2 && $stable(base_s2) && $stable(rnd_s2))
		else $error("stage 2 transaction lost during stall");

endmodule
`default_nettype wire
